// ----- sv/fpa_pkg.sv -----
package fpa_pkg;

  localparam int W      = 32;          // word width
  localparam int F      = 8;           // fraction bits
  localparam int NSTEP  = W + F;       // quotient bits of (|a| << F) / |b|
  localparam int MW     = 2 * W + 1 - F;  // width of rounded magnitudes

  typedef enum logic [3:0] {
    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GT, CMD_LT, CMD_GE, CMD_LE,
    CMD_EQ, CMD_NE, CMD_MIN, CMD_MAX, CMD_INC, CMD_DEC, CMD_TOINT, CMD_FROMINT
  } cmd_t;

  typedef enum logic [1:0] {K_PLAIN, K_MUL, K_DIV, K_DZ} kind_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    kind_t            kind;
    logic             neg;
    logic [W-1:0]     res;
    logic             flag;
    logic [W-1:0]     dvs;
    logic [NSTEP-1:0] num;
    logic [2*W-1:0]   prod;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic [W:0]       rem;
    logic [NSTEP-1:0] quo;
  } stage_t;

endpackage

// ----- sv/fpa_front.sv -----
module fpa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_cmd,
  input  logic signed [31:0]  in_operand_a,
  input  logic signed [31:0]  in_operand_b,
  output fpa_pkg::item_t      q_item,
  output logic                q_valid,
  input  logic                q_pop
);
  import fpa_pkg::*;

  logic signed [W-1:0] a, b;
  logic [W-1:0]        ma, mb;
  logic                lt_ab, lt_ba;
  item_t               it;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign a = in_operand_a;
  assign b = in_operand_b;

  always_comb begin
    lt_ab = a < b;
    lt_ba = b < a;
    ma = a[W-1] ? W'(-a) : W'(a);
    mb = b[W-1] ? W'(-b) : W'(b);
    it.kind = K_PLAIN;
    it.neg  = a[W-1] ^ b[W-1];
    it.res  = '0;
    it.flag = 1'b0;
    it.dvs  = mb;
    it.num  = {ma, F'(0)};
    it.prod = ma * mb;
    case (cmd_t'(in_cmd))
      CMD_ADD:     it.res = W'(a + b);
      CMD_SUB:     it.res = W'(a - b);
      CMD_MUL:     it.kind = K_MUL;
      CMD_DIV:     it.kind = (b == '0) ? K_DZ : K_DIV;
      CMD_GT:      it.flag = lt_ba;
      CMD_LT:      it.flag = lt_ab;
      CMD_GE:      it.flag = !lt_ab;
      CMD_LE:      it.flag = !lt_ba;
      CMD_EQ:      it.flag = (a == b);
      CMD_NE:      it.flag = (a != b);
      CMD_MIN:     it.res = lt_ab ? a : b;
      CMD_MAX:     it.res = lt_ba ? a : b;
      CMD_INC:     it.res = W'(a + W'(1));
      CMD_DEC:     it.res = W'(a - W'(1));
      CMD_TOINT:   it.res = W'(a >>> F);
      CMD_FROMINT: it.res = W'(a << F);
      default:     it.res = '0;
    endcase
  end

  // two-entry queue toward the back end
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= it;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- sv/fpa_back.sv -----
module fpa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fpa_pkg::item_t      q_item,
  input  logic                q_valid,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_result_value,
  output logic                out_compare_flag,
  output logic [1:0]          out_status
);
  import fpa_pkg::*;

  function automatic stage_t dstep(stage_t s);
    stage_t     r;
    logic [W:0] rn;
    logic       qb;
    rn = {s.rem[W-1:0], s.it.num[NSTEP-1]};
    qb = (rn >= {1'b0, s.it.dvs});
    if (qb) rn = rn - {1'b0, s.it.dvs};
    r = s;
    r.rem = rn;
    r.it.num = s.it.num << 1;
    r.quo = {s.quo[NSTEP-2:0], qb};
    return r;
  endfunction

  logic   en;
  stage_t head;
  stage_t stg_r [NSTEP];
  logic   v_r   [NSTEP];

  assign en    = !out_valid || !out_stall;
  assign q_pop = en && q_valid;

  always_comb begin
    head.it  = q_item;
    head.rem = '0;
    head.quo = '0;
  end

  // one restoring-divide step per stage; other kinds just ride along
  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= dstep(head);
      for (int k = 1; k < NSTEP; k++) stg_r[k] <= dstep(stg_r[k-1]);
    end
    if (!rst_n) begin
      for (int k = 0; k < NSTEP; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_valid;
      for (int k = 1; k < NSTEP; k++) v_r[k] <= v_r[k-1];
    end
  end

  // round, saturate, select
  stage_t          t;
  logic [2*W:0]    psum;
  logic [MW-1:0]   mag, lim;
  logic [W:0]      gap;
  logic            up;
  logic [W-1:0]    res;
  logic [1:0]      st;

  always_comb begin
    t    = stg_r[NSTEP-1];
    psum = {1'b0, t.it.prod} + (2*W+1)'(1 << (F-1));
    gap  = {1'b0, t.it.dvs} - t.rem;
    up   = (t.rem >= gap);
    if (t.it.kind == K_MUL) mag = MW'(psum >> F);
    else                    mag = MW'(t.quo) + MW'(up);
    lim = t.it.neg ? (MW'(1) << (W-1)) : ((MW'(1) << (W-1)) - MW'(1));
    res = t.it.res;
    st  = ST_OK;
    case (t.it.kind)
      K_MUL, K_DIV: begin
        if (mag > lim) begin
          st  = ST_SAT;
          res = t.it.neg ? {1'b1, (W-1)'(0)} : {1'b0, {(W-1){1'b1}}};
        end else begin
          res = t.it.neg ? W'(-mag[W-1:0]) : mag[W-1:0];
        end
      end
      K_DZ: begin
        st  = ST_DZ;
        res = '0;
      end
      default: ;
    endcase
  end

  logic            out_valid_r;
  logic [W-1:0]    res_r;
  logic            flag_r;
  logic [1:0]      st_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res;
      flag_r <= t.it.flag;
      st_r   <= st;
    end
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v_r[NSTEP-1];
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_compare_flag = flag_r;
  assign out_status       = st_r;

endmodule

// ----- sv/fixed_point_q24_8_alu.sv -----
// Signed Q24.8 fixed-point ALU.
// Input channel: in_valid / in_stall with in_cmd, in_operand_a, in_operand_b.
// Output channel: out_valid / out_stall with out_result_value,
// out_compare_flag and out_status. An item moves on a clock edge where
// valid is high and stall is low.
// Every operation takes the same path, so results leave in input order.
// Path: an accepted item waits in the two-entry front queue, then passes
// through the 40 divide-step stages and one round/saturate register.
// The 40 stages come from the restoring divider, one quotient bit per
// stage for the 40-bit dividend |a| << 8.
// Throughput: one item per cycle when out_stall is low.
// When out_stall is high while a result waits, the whole back pipeline
// holds; the front queue then fills and in_stall rises once it holds two.
// Reset (rst_n low, synchronous) empties the queue and clears all valid
// bits; no results are pending afterward.
module fixed_point_q24_8_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_cmd,
  input  logic signed [31:0]  in_operand_a,
  input  logic signed [31:0]  in_operand_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_result_value,
  output logic                out_compare_flag,
  output logic [1:0]          out_status
);
  import fpa_pkg::*;

  item_t q_item;
  logic  q_valid, q_pop;

  // decode, compares, simple ops and the magnitude product
  fpa_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_operand_a, .in_operand_b,
    .q_item, .q_valid, .q_pop
  );

  // divide pipeline, rounding, saturation and the output register
  fpa_back u_back (
    .clk, .rst_n, .q_item, .q_valid, .q_pop,
    .out_valid, .out_stall, .out_result_value, .out_compare_flag, .out_status
  );

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import fpa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         in_cmd = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  // result channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic               out_compare_flag;
  logic [1:0]         out_status;

  fixed_point_q24_8_alu dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    cmd_t              op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_op_t;

  typedef struct {
    logic [31:0] value;
    logic        flag;
    logic [1:0]  status;
  } alu_res_t;

  alu_op_t  pending_ops[$];   // items waiting to be driven
  alu_res_t expected_res[$];  // predicted results in arrival order

  int  errors = 0;
  bit  stim_done = 1'b0;
  bit  calm = 1'b0;           // last part of the run: no idling at all
  bit  hold_req = 1'b0;       // ask the receiver for one long hold-off

  // Apply sign and clamp to a magnitude already rounded half away from zero.
  // Magnitudes fit well in 128 bits for both mul and div.
  function automatic alu_res_t signed_finish(logic [127:0] mag, logic neg);
    alu_res_t r;
    r.flag = 1'b0;
    r.status = ST_OK;
    if (!neg && mag > 128'h7FFF_FFFF) begin
      r.value = 32'h7FFF_FFFF;
      r.status = ST_SAT;
    end else if (neg && mag > 128'h8000_0000) begin
      r.value = 32'h8000_0000;
      r.status = ST_SAT;
    end else begin
      r.value = neg ? -mag[31:0] : mag[31:0];
    end
    return r;
  endfunction

  function automatic alu_res_t alu_predict(alu_op_t it);
    alu_res_t r;
    logic signed [31:0] sa, sb;
    logic [127:0] ma, mb, prod, num, quo, rem;
    logic neg;
    sa = it.a;
    sb = it.b;
    ma = sa[31] ? 128'(33'h1_0000_0000 - {1'b0, it.a}) : 128'(it.a);
    mb = sb[31] ? 128'(33'h1_0000_0000 - {1'b0, it.b}) : 128'(it.b);
    neg = sa[31] ^ sb[31];
    r.value = '0;
    r.flag = 1'b0;
    r.status = ST_OK;
    case (it.op)
      CMD_ADD:     r.value = it.a + it.b;
      CMD_SUB:     r.value = it.a - it.b;
      CMD_MUL: begin
        prod = ma * mb + (128'd1 << (F - 1));
        r = signed_finish(prod >> F, neg);
      end
      CMD_DIV: begin
        if (mb == 0) begin
          r.status = ST_DZ;
        end else begin
          num = ma << F;
          quo = num / mb;
          rem = num % mb;
          if (rem >= mb - rem) quo = quo + 1;
          r = signed_finish(quo, neg);
        end
      end
      CMD_GT:      r.flag = sa > sb;
      CMD_LT:      r.flag = sa < sb;
      CMD_GE:      r.flag = sa >= sb;
      CMD_LE:      r.flag = sa <= sb;
      CMD_EQ:      r.flag = sa == sb;
      CMD_NE:      r.flag = sa != sb;
      CMD_MIN:     r.value = (sa < sb) ? it.a : it.b;
      CMD_MAX:     r.value = (sb < sa) ? it.a : it.b;
      CMD_INC:     r.value = it.a + 32'd1;
      CMD_DEC:     r.value = it.a - 32'd1;
      CMD_TOINT:   r.value = sa >>> F;
      CMD_FROMINT: r.value = it.a << F;
      default:     r.value = '0;
    endcase
    return r;
  endfunction

  // Operand pool biased toward the interesting edges.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3: return 32'($urandom_range(0, 2047)) - 32'd1024;     // small values
      4: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
      5: return {8'($urandom_range(0, 255)), 24'h0} ^ 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(cmd_t op, logic [31:0] a, logic [31:0] b);
    alu_op_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    pending_ops.push_back(it);
  endtask

  // Stimulus
  initial begin
    alu_op_t it;
    cmd_t op;
    // directed: extremes, every op, special cases
    push_op(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);       // add wraps
    push_op(CMD_SUB, 32'h8000_0000, 32'h0000_0001);       // sub wraps
    push_op(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);       // saturate high
    push_op(CMD_MUL, 32'h8000_0000, 32'h7FFF_FFFF);       // saturate low
    push_op(CMD_MUL, 32'h8000_0000, 32'h0000_0100);       // exactly min
    push_op(CMD_MUL, 32'h0000_0001, 32'h0000_0080);       // half rounds up
    push_op(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0080);       // half away from zero
    push_op(CMD_DIV, 32'h0000_1234, 32'h0000_0000);       // divide by zero
    push_op(CMD_DIV, 32'h8000_0000, 32'hFFFF_FF00);       // min / -1 saturates
    push_op(CMD_DIV, 32'h8000_0000, 32'h0000_0001);
    push_op(CMD_DIV, 32'h0000_0001, 32'h0000_0200);       // half tie
    push_op(CMD_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    push_op(CMD_GT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(CMD_LT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(CMD_GE, 32'h0000_0005, 32'h0000_0005);
    push_op(CMD_LE, 32'hFFFF_FFFF, 32'h0000_0000);
    push_op(CMD_EQ, 32'h8000_0000, 32'h8000_0000);
    push_op(CMD_NE, 32'h8000_0000, 32'h8000_0000);
    push_op(CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(CMD_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);       // inc wraps, b ignored
    push_op(CMD_DEC, 32'h8000_0000, 32'h1234_5678);
    push_op(CMD_TOINT, 32'h8000_0000, 32'h0);
    push_op(CMD_TOINT, 32'hFFFF_FFFF, 32'h0);             // -1 raw -> -1
    push_op(CMD_FROMINT, 32'h00FF_FFFF, 32'h0);           // fromint wraps
    // random part
    for (int i = 0; i < 1150; i++) begin
      op = cmd_t'($urandom_range(0, 15));
      it.op = op;
      it.a = pick_operand();
      it.b = ($urandom_range(0, 3) == 0) ? it.a : pick_operand();
      pending_ops.push_back(it);
      if (i == 300) hold_req = 1'b1;
      if (i == 1000) calm = 1'b1;
      // keep the queue short so idling and hold-off line up with the run
      while (pending_ops.size() > 40) @(posedge clk);
    end
    // sample between edges so the driver's last update has landed
    while (pending_ops.size() != 0 || in_valid) @(negedge clk);
    stim_done = 1'b1;
  end

  // Reset: held low at the start, released once.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: offers items from pending_ops with random idle bursts.
  int idle_left = 0;
  always @(posedge clk) begin
    alu_op_t it;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_res.push_back(
          alu_predict(alu_op_t'{cmd_t'(in_cmd), in_operand_a, in_operand_b}));
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          idle_left <= $urandom_range(0, 8);  // random idle burst length
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          it = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_cmd <= it.op;
          in_operand_a <= it.a;
          in_operand_b <= it.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold-off so the pipeline
  // fills and in_stall rises while the driver keeps offering.
  int stall_left = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req && !hold_done) begin
        if (hold_cnt < 120) begin
          hold_cnt <= hold_cnt + 1;
          out_stall <= 1'b1;
        end else begin
          hold_done <= 1'b1;
          out_stall <= 1'b0;
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result value=%h", out_result_value);
        errors++;
      end else begin
        exp_r = expected_res.pop_front();
        if (out_result_value !== exp_r.value) begin
          $error("result_value exp %h got %h", exp_r.value, out_result_value);
          errors++;
        end
        if (out_compare_flag !== exp_r.flag) begin
          $error("compare_flag exp %b got %b", exp_r.flag, out_compare_flag);
          errors++;
        end
        if (out_status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_status);
          errors++;
        end
      end
    end
  end

  // End of run: drain, then allow the pipeline latency to pass.
  initial begin
    wait (stim_done);
    while (expected_res.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
